// File: src/rgbconv_pkg.sv
// ----------------------------------------------------------------------------
// rgbconv_pkg
// Types, widths and register codes shared by the 3x3 RGB convolution block.
// ----------------------------------------------------------------------------
package rgbconv_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int COEF_FRAC_DEF  = 12;

	localparam int CH_W        = 8;
	localparam int PIX_W       = 3 * CH_W;
	localparam int WEIGHT_W    = 16;
	localparam int COEF_W      = 3 * WEIGHT_W;
	localparam int WIDTH_REG_W = 12;
	localparam int HEIGHT_W    = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = COEF_W;

	localparam int PROD_W = CH_W + 1 + WEIGHT_W;
	localparam int ROW_W  = PROD_W + 2;
	localparam int SUM_W  = ROW_W + 2;

	localparam logic [COEF_W-1:0]      COEF_TOP_RST    = 48'h0;
	localparam logic [COEF_W-1:0]      COEF_MIDDLE_RST = 48'h0000_1000_0000;
	localparam logic [COEF_W-1:0]      COEF_BOTTOM_RST = 48'h0;
	localparam logic [WIDTH_REG_W-1:0] WIDTH_RST       = 12'd640;
	localparam logic [HEIGHT_W-1:0]    HEIGHT_RST      = 16'd480;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_TOP     = 3'd0,
		REG_COEF_MIDDLE  = 3'd1,
		REG_COEF_BOTTOM  = 3'd2,
		REG_IMAGE_WIDTH  = 3'd3,
		REG_IMAGE_HEIGHT = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic            kind;
		logic [CH_W-1:0] blue_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] red_in;
	} in_t;

	typedef struct packed {
		logic [CH_W-1:0] blue_out;
		logic [CH_W-1:0] green_out;
		logic [CH_W-1:0] red_out;
		logic            frame_end;
	} out_t;

	// position of a transaction: whether it yields a result and which taps fall outside
	typedef struct packed {
		logic lead;
		logic top;
		logic bottom;
		logic left;
		logic right;
		logic last;
	} pos_t;

	typedef logic [2:0][2:0][PIX_W-1:0] win_t;

endpackage

// File: src/rgb_conv3x3_zero_pad.sv
// ----------------------------------------------------------------------------
// rgb_conv3x3_zero_pad
// Streaming 3x3 convolution per colour channel, zero outside the image.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while px_stall is low; results leave at
//   one per cycle while res_stall is low. A result is registered in s1, window,
//   s3, s4 and output; its transaction is image_width+1 after its own pixel.
// px_stall rises only when both the output register and skid stage hold results.
// Reset: counters, window and registers to their defaults; line stores are not
//   cleared, unwritten entries only reach taps outside the image.
module rgb_conv3x3_zero_pad #(
	parameter int MAX_WIDTH      = rgbconv_pkg::MAX_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = rgbconv_pkg::COEF_FRAC_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               px_valid,
	output logic                               px_stall,
	input  rgbconv_pkg::in_t                   px_data,
	output logic                               res_valid,
	input  logic                               res_stall,
	output rgbconv_pkg::out_t                  res_data,
	input  logic                               cfg_we,
	input  logic [rgbconv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rgbconv_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rgbconv_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);

	logic [COEF_W-1:0]      coef_top_q, coef_middle_q, coef_bottom_q;
	logic [WIDTH_REG_W-1:0] width_q;
	logic [HEIGHT_W-1:0]    height_q;
	logic                   adv;
	logic                   accept;
	logic [COL_W-1:0]       col;
	pos_t                   pos;
	win_t                   win;
	logic                   valid_s2;
	pos_t                   pos_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_top_q    <= COEF_TOP_RST;
			coef_middle_q <= COEF_MIDDLE_RST;
			coef_bottom_q <= COEF_BOTTOM_RST;
			width_q       <= WIDTH_RST;
			height_q      <= HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_COEF_TOP:     coef_top_q    <= cfg_data;
				REG_COEF_MIDDLE:  coef_middle_q <= cfg_data;
				REG_COEF_BOTTOM:  coef_bottom_q <= cfg_data;
				REG_IMAGE_WIDTH:  width_q       <= cfg_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: height_q      <= cfg_data[HEIGHT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign px_stall = !adv;
	assign accept   = px_valid && adv;

	rgbconv_ctrl #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.image_width  (width_q),
		.image_height (height_q),
		.col          (col),
		.pos          (pos)
	);

	rgbconv_window #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.accept   (accept),
		.px       (px_data),
		.col      (col),
		.pos      (pos),
		.win      (win),
		.valid_s2 (valid_s2),
		.pos_s2   (pos_s2)
	);

	rgbconv_mac #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s2    (valid_s2),
		.pos_s2      (pos_s2),
		.win         (win),
		.coef_top    (coef_top_q),
		.coef_middle (coef_middle_q),
		.coef_bottom (coef_bottom_q),
		.adv         (adv),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res_data    (res_data)
	);

endmodule

// File: src/rgbconv_ram.sv
// ----------------------------------------------------------------------------
// rgbconv_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module rgbconv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

// File: src/rgbconv_ctrl.sv
// ----------------------------------------------------------------------------
// rgbconv_ctrl
// Input and output position counters; flags each transaction's border taps.
// ----------------------------------------------------------------------------
module rgbconv_ctrl #(
	parameter int MAX_WIDTH = rgbconv_pkg::MAX_WIDTH_DEF,
	localparam int COL_W    = $clog2(MAX_WIDTH)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic [rgbconv_pkg::WIDTH_REG_W-1:0] image_width,
	input  logic [rgbconv_pkg::HEIGHT_W-1:0]    image_height,
	output logic [COL_W-1:0]                    col,
	output rgbconv_pkg::pos_t                   pos
);
	import rgbconv_pkg::*;

	localparam int CW = (COL_W + 1 > WIDTH_REG_W) ? COL_W + 1 : WIDTH_REG_W;
	localparam int HW = HEIGHT_W + 1;
	localparam logic [1:0] ROW_FULL = 2'd2;

	logic [COL_W-1:0]    in_col_q, in_col_d;
	logic [1:0]          in_row_q, in_row_d;
	logic [COL_W-1:0]    out_col_q, out_col_d;
	logic [HEIGHT_W-1:0] out_row_q, out_row_d;
	logic [CW-1:0]       w_eff;
	logic [HW-1:0]       h_eff;
	logic                in_end;

	always_comb begin
		if (image_width == '0) begin
			w_eff = CW'(1);
		end else if (CW'(image_width) > CW'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(image_width);
		end
		h_eff = (image_height == '0) ? HW'(1) : HW'(image_height);

		in_end     = (CW'(in_col_q) + CW'(1)) >= w_eff;
		pos.lead   = (in_row_q == ROW_FULL) || (in_row_q == 2'd1 && in_col_q != '0);
		pos.top    = (out_row_q == '0);
		pos.bottom = (HW'(out_row_q) + HW'(1)) >= h_eff;
		pos.left   = (out_col_q == '0);
		pos.right  = (CW'(out_col_q) + CW'(1)) >= w_eff;
		pos.last   = pos.bottom && pos.right;

		in_col_d  = in_col_q;
		in_row_d  = in_row_q;
		out_col_d = out_col_q;
		out_row_d = out_row_q;
		if (accept) begin
			if (in_end) begin
				in_col_d = '0;
				if (in_row_q != ROW_FULL) begin
					in_row_d = in_row_q + 2'd1;
				end
			end else begin
				in_col_d = in_col_q + COL_W'(1);
			end
			if (pos.lead) begin
				if (pos.last) begin
					in_col_d  = '0;
					in_row_d  = '0;
					out_col_d = '0;
					out_row_d = '0;
				end else if (pos.right) begin
					out_col_d = '0;
					out_row_d = out_row_q + HEIGHT_W'(1);
				end else begin
					out_col_d = out_col_q + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else begin
			in_col_q  <= in_col_d;
			in_row_q  <= in_row_d;
			out_col_q <= out_col_d;
			out_row_q <= out_row_d;
		end
	end

	assign col = in_col_q;

endmodule

// File: src/rgbconv_window.sv
// ----------------------------------------------------------------------------
// rgbconv_window
// Two line stores in one RAM and the 3x3 neighbourhood window.
// ----------------------------------------------------------------------------
module rgbconv_window #(
	parameter int MAX_WIDTH = rgbconv_pkg::MAX_WIDTH_DEF,
	localparam int COL_W    = $clog2(MAX_WIDTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              accept,
	input  rgbconv_pkg::in_t  px,
	input  logic [COL_W-1:0]  col,
	input  rgbconv_pkg::pos_t pos,
	output rgbconv_pkg::win_t win,
	output logic              valid_s2,
	output rgbconv_pkg::pos_t pos_s2
);
	import rgbconv_pkg::*;

	localparam int LW = 2 * PIX_W;

	logic             valid_s1;
	pos_t             pos_s1;
	logic [COL_W-1:0] col_s1;
	logic [PIX_W-1:0] pix_s1;
	logic             fwd_s1;
	logic [LW-1:0]    fwd_data_q;
	logic [LW-1:0]    ram_rd;
	logic [LW-1:0]    lines;
	logic [PIX_W-1:0] above;
	logic [PIX_W-1:0] mid;
	logic             wr_en;
	win_t             window_q;

	// entry holds {upper line, middle line}
	rgbconv_ram #(
		.WIDTH (LW),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (wr_en),
		.waddr (col_s1),
		.wdata ({mid, pix_s1}),
		.re    (accept),
		.raddr (col),
		.rdata (ram_rd)
	);

	assign wr_en = valid_s1 && adv;
	assign lines = fwd_s1 ? fwd_data_q : ram_rd;
	assign above = lines[LW-1:PIX_W];
	assign mid   = lines[PIX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			window_q <= '0;
		end else if (adv) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1 && pos_s1.lead;
			if (valid_s1) begin
				for (int r = 0; r < 3; r++) begin
					window_q[r][0] <= window_q[r][1];
					window_q[r][1] <= window_q[r][2];
				end
				window_q[0][2] <= above;
				window_q[1][2] <= mid;
				window_q[2][2] <= pix_s1;
			end
		end
	end

	// a read of the column being written in the same cycle takes the new data
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1     <= pos;
			col_s1     <= col;
			pix_s1     <= px.kind ? '0 : {px.red_in, px.green_in, px.blue_in};
			fwd_s1     <= valid_s1 && (col_s1 == col);
			fwd_data_q <= {mid, pix_s1};
		end
		if (adv) begin
			pos_s2 <= pos_s1;
		end
	end

	assign win = window_q;

endmodule

// File: src/rgbconv_mac.sv
// ----------------------------------------------------------------------------
// rgbconv_mac
// Masked products, row sums, final sum with saturation, output skid buffer.
// ----------------------------------------------------------------------------
module rgbconv_mac #(
	parameter int COEF_FRAC_BITS = rgbconv_pkg::COEF_FRAC_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           valid_s2,
	input  rgbconv_pkg::pos_t              pos_s2,
	input  rgbconv_pkg::win_t              win,
	input  logic [rgbconv_pkg::COEF_W-1:0] coef_top,
	input  logic [rgbconv_pkg::COEF_W-1:0] coef_middle,
	input  logic [rgbconv_pkg::COEF_W-1:0] coef_bottom,
	output logic                           adv,
	output logic                           res_valid,
	input  logic                           res_stall,
	output rgbconv_pkg::out_t              res_data
);
	import rgbconv_pkg::*;

	localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(255);

	logic [COEF_W-1:0]          coefs [3];
	logic signed [PROD_W-1:0]   prod_d  [3][3][3];
	logic signed [PROD_W-1:0]   prod_s3 [3][3][3];
	logic signed [ROW_W-1:0]    row_d   [3][3];
	logic signed [ROW_W-1:0]    row_s4  [3][3];
	logic signed [SUM_W-1:0]    sum     [3];
	logic signed [SUM_W-1:0]    quot    [3];
	logic [CH_W-1:0]            chan    [3];
	logic                       valid_s3, valid_s4;
	logic                       last_s3, last_s4;
	out_t                       result;
	out_t                       out_q, skid_q;
	logic                       out_valid_q, skid_valid_q;
	logic                       take;

	assign coefs[0] = coef_top;
	assign coefs[1] = coef_middle;
	assign coefs[2] = coef_bottom;

	always_comb begin
		logic                       on;
		logic signed [WEIGHT_W-1:0] wt;
		logic [CH_W-1:0]            p;
		for (int ch = 0; ch < 3; ch++) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					on = !((r == 0 && pos_s2.top) || (r == 2 && pos_s2.bottom) ||
					       (c == 0 && pos_s2.left) || (c == 2 && pos_s2.right));
					wt = $signed(coefs[r][WEIGHT_W*c +: WEIGHT_W]);
					p  = win[r][c][CH_W*ch +: CH_W];
					prod_d[ch][r][c] = on ?
						PROD_W'($signed({1'b0, p})) * PROD_W'(wt) : '0;
				end
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int r = 0; r < 3; r++) begin
				row_d[ch][r] = ROW_W'(prod_s3[ch][r][0]) + ROW_W'(prod_s3[ch][r][1]) +
				               ROW_W'(prod_s3[ch][r][2]);
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum[ch]  = SUM_W'(row_s4[ch][0]) + SUM_W'(row_s4[ch][1]) + SUM_W'(row_s4[ch][2]);
			quot[ch] = sum[ch] >>> COEF_FRAC_BITS;
			if (sum[ch][SUM_W-1] || sum[ch] == '0) begin
				chan[ch] = '0;
			end else if (quot[ch] > SAT_MAX) begin
				chan[ch] = '1;
			end else begin
				chan[ch] = quot[ch][CH_W-1:0];
			end
		end
		result.blue_out  = chan[0];
		result.green_out = chan[1];
		result.red_out   = chan[2];
		result.frame_end = last_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= prod_d;
			row_s4  <= row_d;
			last_s3 <= pos_s2.last;
			last_s4 <= last_s3;
		end
	end

	assign adv  = !skid_valid_q;
	assign take = out_valid_q && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3     <= 1'b0;
			valid_s4     <= 1'b0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				valid_s3 <= valid_s2;
				valid_s4 <= valid_s3;
			end
			if (skid_valid_q) begin
				if (take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (valid_s4) begin
				if (!out_valid_q || take) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (valid_s4) begin
			if (!out_valid_q || take) begin
				out_q <= result;
			end else begin
				skid_q <= result;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_q;

endmodule

// File: src/rgbconv_checker.sv
// ----------------------------------------------------------------------------
// rgbconv_checker
// Port-level checks on the output buffering of the convolution block.
// ----------------------------------------------------------------------------
module rgbconv_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              px_stall,
	input logic              res_valid,
	input logic              res_stall,
	input rgbconv_pkg::out_t res_data
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("stalled result changed");

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		px_stall |-> res_valid)
		else $error("input stalled with empty output register");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(px_stall) |-> $past(res_valid && res_stall))
		else $error("input stall without output back-pressure");

	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		px_stall && !res_stall |=> !px_stall)
		else $error("skid stage not drained after transaction");

endmodule

bind rgb_conv3x3_zero_pad rgbconv_checker u_checker (.*);
